FILE: design/assert_macros.svh
// Assertion macros shared by the sequence-control unit.
// No dependencies; included by the top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`define ASSERT_IMPL(lbl, clk, rstn, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (c)) \
    else $error("assertion failed");
`define ASSERT_NEXT(lbl, clk, rstn, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (c)) \
    else $error("assertion failed");
`endif

FILE: design/qscu_pkg.sv
// Package for the QoS sequence-control unit: table ids, FSM states, constants.
// No dependencies.
package qscu_pkg;
  localparam int unsigned SeqW = 12;
  localparam int unsigned KeyW = 52;
  localparam int unsigned ValW = 16;
  localparam int unsigned DefEntries = 16;
  localparam int unsigned GroupBit = 40;

  typedef enum logic [1:0] {
    TblTxData   = 2'd0,
    TblTxShared = 2'd1,
    TblRxShared = 2'd2,
    TblRxData   = 2'd3
  } tbl_e;

  typedef enum logic [2:0] {
    StIdle,
    StScan,
    StRead,
    StDecide,
    StOut
  } state_e;

  // lookup and update control from sequencer to table bank
  typedef struct packed {
    logic             scan_en;
    logic             rd_en;
    logic             wr_en;
    logic             ins;
    tbl_e             tbl;
  } tbl_ctl_t;
endpackage

FILE: design/qscu_table.sv
// One associative table: keys and values in memories, valid bits in flops.
// Scanned entry by entry by the sequencer. Depends on qscu_pkg.
module qscu_table #(
  parameter int unsigned Entries = qscu_pkg::DefEntries,
  localparam int unsigned IdxW = (Entries > 1) ? $clog2(Entries) : 1
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     sel_i,
  input  qscu_pkg::tbl_ctl_t       ctl_i,
  input  logic [IdxW-1:0]          idx_i,
  input  logic [qscu_pkg::KeyW-1:0] key_i,
  input  logic [qscu_pkg::ValW-1:0] val_i,
  output logic                     hit_o,
  output logic [qscu_pkg::ValW-1:0] val_o,
  output logic [IdxW-1:0]          ptr_o
);
  import qscu_pkg::*;
  logic [KeyW-1:0] keys [Entries];
  logic [ValW-1:0] vals [Entries];
  logic [Entries-1:0] valid_q;
  logic [IdxW-1:0] ptr_q;
  logic [KeyW-1:0] key_rd_q;
  logic vld_rd_q;

  always_ff @(posedge clk_i) begin
    if (sel_i && ctl_i.scan_en) key_rd_q <= keys[idx_i];
    if (sel_i && ctl_i.rd_en) val_o <= vals[idx_i];
    if (sel_i && ctl_i.wr_en) begin
      vals[idx_i] <= val_i;
      if (ctl_i.ins) keys[idx_i] <= key_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      ptr_q <= '0;
      vld_rd_q <= 1'b0;
    end else begin
      if (sel_i && ctl_i.scan_en) vld_rd_q <= valid_q[idx_i];
      if (sel_i && ctl_i.wr_en && ctl_i.ins) begin
        valid_q[idx_i] <= 1'b1;
        ptr_q <= (ptr_q == IdxW'(Entries - 1)) ? '0 : ptr_q + 1'b1;
      end
    end
  end

  assign hit_o = vld_rd_q && (key_rd_q == key_i);
  assign ptr_o = ptr_q;
endmodule

FILE: design/qos_sequence_control_unit.sv
// Top level of the QoS sequence-control unit: sequencer, shared compare/update
// unit and four tables. Depends on qscu_pkg, qscu_table, assert_macros.svh.
//
//  channel | direction | handshake
//  in      | input     | in_valid_i / in_stall_o
//  out     | output    | out_valid_o / out_stall_i
//
// An item is taken from idle, then each table entry is scanned with a read and
// a compare step up to the first hit or the last entry, then a decide and an
// output step follow. Reset clears valid bits, pointers and the shared counter
// at once. A stalled result waits in the output register; the next item is
// taken meanwhile and holds before its decide step until that result is taken.
module qos_sequence_control_unit #(
  parameter int unsigned TX_DATA_ENTRIES   = qscu_pkg::DefEntries,
  parameter int unsigned TX_SHARED_ENTRIES = qscu_pkg::DefEntries,
  parameter int unsigned RX_SHARED_ENTRIES = qscu_pkg::DefEntries,
  parameter int unsigned RX_DATA_ENTRIES   = qscu_pkg::DefEntries
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        cmd_i,
  input  logic [47:0] peer_address_i,
  input  logic [3:0]  traffic_id_i,
  input  logic        qos_data_i,
  input  logic        management_i,
  input  logic [11:0] seq_in_i,
  input  logic [3:0]  frag_in_i,
  input  logic        retry_bit_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [11:0] seq_out_o,
  output logic        duplicate_o
);
  import qscu_pkg::*;
  localparam int unsigned MaxE = (TX_DATA_ENTRIES > TX_SHARED_ENTRIES ?
      TX_DATA_ENTRIES : TX_SHARED_ENTRIES) > (RX_SHARED_ENTRIES > RX_DATA_ENTRIES ?
      RX_SHARED_ENTRIES : RX_DATA_ENTRIES) ? (TX_DATA_ENTRIES > TX_SHARED_ENTRIES ?
      TX_DATA_ENTRIES : TX_SHARED_ENTRIES) : (RX_SHARED_ENTRIES > RX_DATA_ENTRIES ?
      RX_SHARED_ENTRIES : RX_DATA_ENTRIES);
  localparam int unsigned CntW = $clog2(MaxE + 1);
  localparam int unsigned W0 = (TX_DATA_ENTRIES > 1) ? $clog2(TX_DATA_ENTRIES) : 1;
  localparam int unsigned W1 = (TX_SHARED_ENTRIES > 1) ? $clog2(TX_SHARED_ENTRIES) : 1;
  localparam int unsigned W2 = (RX_SHARED_ENTRIES > 1) ? $clog2(RX_SHARED_ENTRIES) : 1;
  localparam int unsigned W3 = (RX_DATA_ENTRIES > 1) ? $clog2(RX_DATA_ENTRIES) : 1;

  state_e state_q, state_d;
  tbl_e tbl_q, tbl_d;
  logic [KeyW-1:0] key_q, key_d;
  logic [ValW-1:0] sf_q, sf_d;
  logic retry_q, retry_d;
  logic [CntW-1:0] idx_q, idx_d, n_entries;
  logic hit_q, hit_d;
  logic [SeqW-1:0] shared_q, shared_d;
  logic [SeqW-1:0] seq_q, seq_d;
  logic dup_q, dup_d;
  logic out_valid_q, out_valid_d;
  tbl_ctl_t ctl;
  logic [ValW-1:0] wval;
  logic [CntW-1:0] widx;
  logic [3:0] hit_v;
  logic [ValW-1:0] rv [4];
  logic [W0-1:0] p0; logic [W1-1:0] p1; logic [W2-1:0] p2; logic [W3-1:0] p3;
  logic cur_hit, last_idx;
  logic [ValW-1:0] cur_val;
  logic [CntW-1:0] cur_ptr;

  always_comb begin
    unique case (tbl_q)
      TblTxData:   begin n_entries = CntW'(TX_DATA_ENTRIES);   cur_ptr = CntW'(p0); end
      TblTxShared: begin n_entries = CntW'(TX_SHARED_ENTRIES); cur_ptr = CntW'(p1); end
      TblRxShared: begin n_entries = CntW'(RX_SHARED_ENTRIES); cur_ptr = CntW'(p2); end
      default:     begin n_entries = CntW'(RX_DATA_ENTRIES);   cur_ptr = CntW'(p3); end
    endcase
    cur_hit = hit_v[tbl_q];
    cur_val = rv[tbl_q];
  end
  assign last_idx = (idx_q == n_entries - 1'b1);

  qscu_table #(.Entries(TX_DATA_ENTRIES)) u_tx_data (
    .clk_i, .rst_ni, .sel_i(tbl_q == TblTxData), .ctl_i(ctl), .idx_i(widx[W0-1:0]),
    .key_i(key_q), .val_i(wval), .hit_o(hit_v[0]), .val_o(rv[0]), .ptr_o(p0));
  qscu_table #(.Entries(TX_SHARED_ENTRIES)) u_tx_shared (
    .clk_i, .rst_ni, .sel_i(tbl_q == TblTxShared), .ctl_i(ctl), .idx_i(widx[W1-1:0]),
    .key_i(key_q), .val_i(wval), .hit_o(hit_v[1]), .val_o(rv[1]), .ptr_o(p1));
  qscu_table #(.Entries(RX_SHARED_ENTRIES)) u_rx_shared (
    .clk_i, .rst_ni, .sel_i(tbl_q == TblRxShared), .ctl_i(ctl), .idx_i(widx[W2-1:0]),
    .key_i(key_q), .val_i(wval), .hit_o(hit_v[2]), .val_o(rv[2]), .ptr_o(p2));
  qscu_table #(.Entries(RX_DATA_ENTRIES)) u_rx_data (
    .clk_i, .rst_ni, .sel_i(tbl_q == TblRxData), .ctl_i(ctl), .idx_i(widx[W3-1:0]),
    .key_i(key_q), .val_i(wval), .hit_o(hit_v[3]), .val_o(rv[3]), .ptr_o(p3));

  always_comb begin
    state_d = state_q; tbl_d = tbl_q; key_d = key_q; sf_d = sf_q; retry_d = retry_q;
    idx_d = idx_q; hit_d = hit_q; shared_d = shared_q; seq_d = seq_q; dup_d = dup_q;
    out_valid_d = out_valid_q;
    ctl = '{scan_en: 1'b0, rd_en: 1'b0, wr_en: 1'b0, ins: 1'b0, tbl: tbl_q};
    wval = '0;
    widx = idx_q;
    if (out_valid_q && !out_stall_i) out_valid_d = 1'b0;
    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          idx_d = '0; hit_d = 1'b0; retry_d = retry_bit_i;
          sf_d = {seq_in_i, frag_in_i};
          if (!cmd_i) begin
            if (qos_data_i && !peer_address_i[GroupBit]) begin
              tbl_d = TblTxData; key_d = {peer_address_i, traffic_id_i};
            end else begin
              tbl_d = TblTxShared; key_d = {4'd0, peer_address_i};
            end
          end else if (management_i) begin
            tbl_d = TblRxShared; key_d = {4'd0, peer_address_i};
          end else begin
            tbl_d = TblRxData; key_d = {peer_address_i, traffic_id_i};
          end
          state_d = StScan;
        end
      end
      StScan: begin
        ctl.scan_en = 1'b1;
        state_d = StRead;
      end
      StRead: begin
        // key read of idx_q is now registered; compare
        if (cur_hit) begin
          hit_d = 1'b1; ctl.rd_en = 1'b1; state_d = StDecide;
        end else if (last_idx) begin
          hit_d = 1'b0; state_d = StDecide;
        end else begin
          idx_d = idx_q + 1'b1; state_d = StScan;
        end
      end
      StDecide: begin
        // hold the table update until the output register is free
        if (!(out_valid_q && out_stall_i)) begin
          ctl.wr_en = 1'b1;
          ctl.ins = !hit_q;
          widx = hit_q ? idx_q : cur_ptr;
          seq_d = '0; dup_d = 1'b0;
          unique case (tbl_q)
            TblTxData: begin
              wval = hit_q ? {4'd0, cur_val[SeqW-1:0] + 1'b1} : '0;
              seq_d = wval[SeqW-1:0];
            end
            TblTxShared: begin
              if (hit_q && cur_val[SeqW-1:0] == shared_q) begin
                shared_d = shared_q + 1'b1;
              end
              wval = {4'd0, shared_d};
              seq_d = shared_d;
            end
            default: begin
              wval = sf_q;
              if (hit_q && cur_val == sf_q && retry_q) begin
                dup_d = 1'b1; ctl.wr_en = 1'b0;
              end
            end
          endcase
          state_d = StOut;
        end
      end
      StOut: begin
        out_valid_d = 1'b1;
        state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      tbl_q <= TblTxData;
      idx_q <= '0;
      hit_q <= 1'b0;
      shared_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      tbl_q <= tbl_d;
      idx_q <= idx_d;
      hit_q <= hit_d;
      shared_q <= shared_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d; sf_q <= sf_d; retry_q <= retry_d; seq_q <= seq_d; dup_q <= dup_d;
  end

  assign in_stall_o = (state_q != StIdle);
  assign out_valid_o = out_valid_q;
  assign seq_out_o = seq_q;
  assign duplicate_o = dup_q;

`include "assert_macros.svh"
  `ASSERT_IMPL(a_busy_stall, clk_i, rst_ni, state_q != StIdle, in_stall_o)
  `ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i,
      out_valid_o && $stable(seq_out_o) && $stable(duplicate_o))
  `ASSERT_IMPL(a_dup_rx, clk_i, rst_ni, out_valid_o && duplicate_o, seq_out_o == '0)
endmodule
